// ----- rtl/core/fsd_pkg.sv -----
// ----------------------------------------------------------------------------
// fsd_pkg
// Types, constants and arithmetic helpers shared by the RGB332 dither core.
// ----------------------------------------------------------------------------
package fsd_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = 16;
  localparam int LW_W       = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  localparam int CH_RED   = 2;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 0;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] color_index;
    logic       end_of_row;
    logic       end_of_image;
  } result_t;

  typedef logic signed [7:0] err_t;
  typedef err_t [2:0] err3_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             col_zero;
    logic             last_col;
    logic             last_row;
    logic             first_row;
  } pix_ctrl_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    err3_t            data;
  } mem_wr_t;

  typedef struct packed {
    logic [2:0] top;
    err_t       err;
  } quant_t;

  function automatic logic [7:0] level3(input logic [2:0] k);
    logic [7:0] lev;
    case (k)
      3'd0:    lev = 8'd0;
      3'd1:    lev = 8'd36;
      3'd2:    lev = 8'd73;
      3'd3:    lev = 8'd109;
      3'd4:    lev = 8'd146;
      3'd5:    lev = 8'd182;
      3'd6:    lev = 8'd219;
      default: lev = 8'd255;
    endcase
    return lev;
  endfunction

  function automatic logic [7:0] level2(input logic [1:0] k);
    logic [7:0] lev;
    case (k)
      2'd0:    lev = 8'd0;
      2'd1:    lev = 8'd85;
      2'd2:    lev = 8'd170;
      default: lev = 8'd255;
    endcase
    return lev;
  endfunction

  // Divide by 16 with truncation toward zero.
  function automatic err_t frac16(input logic signed [10:0] p);
    logic signed [10:0] a;
    a = p + (p[10] ? 11'sd15 : 11'sd0);
    return err_t'(a >>> 4);
  endfunction

  function automatic quant_t quantize(input logic [7:0] chan, input err_t carry,
                                      input err_t above, input logic two_bit);
    logic signed [9:0] v;
    logic [7:0]        u;
    logic [7:0]        lev;
    quant_t            q;
    v = signed'({2'b00, chan}) + 10'(carry) + 10'(above);
    if (v < 10'sd0) begin
      u = 8'd0;
    end else if (v > 10'sd255) begin
      u = 8'd255;
    end else begin
      u = v[7:0];
    end
    if (two_bit) begin
      q.top = {1'b0, u[7:6]};
      lev   = level2(u[7:6]);
    end else begin
      q.top = u[7:5];
      lev   = level3(u[7:5]);
    end
    q.err = err_t'(signed'({1'b0, u}) - signed'({1'b0, lev}));
    return q;
  endfunction

endpackage

// ----- rtl/core/fsd_err_mem.sv -----
// ----------------------------------------------------------------------------
// fsd_err_mem
// Row error store: one write port, one registered read port with write bypass.
// ----------------------------------------------------------------------------
module fsd_err_mem (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [fsd_pkg::COL_W-1:0] rd_addr,
  output fsd_pkg::err3_t            rd_data,
  input  fsd_pkg::mem_wr_t          wr
);
  import fsd_pkg::*;

  err3_t mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      if (wr.en && (wr.addr == rd_addr)) begin
        rd_data <= wr.data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

// ----- rtl/core/fsd_core.sv -----
// ----------------------------------------------------------------------------
// fsd_core
// Quantizer and error diffusion datapath with right carry and pending sums.
// ----------------------------------------------------------------------------
module fsd_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  fsd_pkg::pix_ctrl_t ctrl,
  input  fsd_pkg::pixel_t    pix,
  input  fsd_pkg::err3_t     above,
  output fsd_pkg::result_t   result,
  output fsd_pkg::mem_wr_t   mem_wr
);
  import fsd_pkg::*;

  err3_t carry, carry_next;
  err3_t ps0, ps0_next;
  err3_t ps1, ps1_next;
  err3_t below_data;
  logic [7:0] chan [3];
  quant_t q [3];
  mem_wr_t stage_wr;
  logic def_valid, def_valid_next;
  logic [COL_W-1:0] def_addr;
  err3_t def_data;

  assign chan[CH_RED]   = pix.red;
  assign chan[CH_GREEN] = pix.green;
  assign chan[CH_BLUE]  = pix.blue;

  always_comb begin
    err_t e7, e5, e3, e1, pend;
    for (int c = 0; c < 3; c++) begin
      q[c] = quantize(chan[c], carry[c], ctrl.first_row ? 8'sd0 : above[c], c == CH_BLUE);
      e7 = frac16(11'(q[c].err) * 11'sd7);
      e5 = frac16(11'(q[c].err) * 11'sd5);
      e3 = frac16(11'(q[c].err) * 11'sd3);
      e1 = frac16(11'(q[c].err));
      pend = ctrl.col_zero ? 8'sd0 : ps1[c];
      carry_next[c] = ctrl.last_col ? 8'sd0 : e7;
      below_data[c] = err_t'(ps0[c] + e3);
      ps0_next[c] = err_t'(pend + e5);
      ps1_next[c] = ctrl.last_col ? 8'sd0 : e1;
    end
  end

  assign result.color_index  = {q[CH_RED].top, q[CH_GREEN].top, q[CH_BLUE].top[1:0]};
  assign result.end_of_row   = ctrl.last_col;
  assign result.end_of_image = ctrl.last_col && ctrl.last_row;

  // The last column of a row produces two store entries; the second is
  // written in the next cycle, in which no stage write can occur.
  always_comb begin
    stage_wr.en   = adv && !ctrl.last_row && (!ctrl.col_zero || ctrl.last_col);
    stage_wr.addr = ctrl.col_zero ? ctrl.col : ctrl.col - COL_W'(1);
    stage_wr.data = ctrl.col_zero ? ps0_next : below_data;
    def_valid_next = adv && !ctrl.last_row && ctrl.last_col && !ctrl.col_zero;
    if (stage_wr.en) begin
      mem_wr = stage_wr;
    end else begin
      mem_wr.en   = def_valid;
      mem_wr.addr = def_addr;
      mem_wr.data = def_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carry     <= '0;
      ps0       <= '0;
      ps1       <= '0;
      def_valid <= 1'b0;
    end else begin
      def_valid <= def_valid_next;
      if (adv) begin
        carry <= carry_next;
        if (!ctrl.last_row) begin
          ps0 <= ps0_next;
          ps1 <= ps1_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (def_valid_next) begin
      def_addr <= ctrl.col;
      def_data <= ps0_next;
    end
  end

  a_single_write: assert property (@(posedge clk) disable iff (rst)
    !(def_valid && stage_wr.en))
    else $error("Deferred store write collides with a stage write.");

  a_def_one_cycle: assert property (@(posedge clk) disable iff (rst)
    def_valid |=> !def_valid)
    else $error("Deferred store write pending on two consecutive cycles.");

  a_def_after_row: assert property (@(posedge clk) disable iff (rst)
    def_valid |-> $past(adv && ctrl.last_col))
    else $error("Deferred store write without a finished row.");

endmodule

// ----- rtl/core/floyd_steinberg_rgb332_dither.sv -----
// ----------------------------------------------------------------------------
// floyd_steinberg_rgb332_dither
// Floyd-Steinberg dither of raster RGB888 pixels to RRRGGGBB palette indexes.
//
//   Channel  Signals                                   Transaction
//   pixel    pixel_valid, pixel_stall, pixel           valid && !stall
//   result   result_valid, result_stall, result        valid && !stall
//   config   cfg_valid, cfg_ready, cfg_index, cfg_data valid && ready
//
// One pixel per clock is accepted unless the result stalls; results pass the
// quantizer and output registers. The row error store is a synchronous RAM read
// as its pixel is taken; the right-neighbor loop closes via the carry register.
// Reset is synchronous; the error store needs no clearing pass.
// A stalled result holds the quantizer stage, which then stalls the input.
// ----------------------------------------------------------------------------
module floyd_steinberg_rgb332_dither (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           pixel_valid,
  output logic                           pixel_stall,
  input  fsd_pkg::pixel_t                pixel,
  output logic                           result_valid,
  input  logic                           result_stall,
  output fsd_pkg::result_t               result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fsd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fsd_pkg::*;

  logic [LW_W-1:0]  line_width;
  logic [ROW_W-1:0] image_height;
  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] last_col_idx;
  logic [ROW_W-1:0] last_row_idx;
  logic             last_col, last_row;
  logic             accept;
  logic             s1_valid, s1_adv;
  pix_ctrl_t        s1_ctrl;
  pixel_t           s1_pix;
  err3_t            above;
  result_t          core_result;
  mem_wr_t          mem_wr;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (line_width == '0) begin
      last_col_idx = '0;
    end else if (line_width > LW_W'(MAX_WIDTH)) begin
      last_col_idx = COL_W'(MAX_WIDTH - 1);
    end else begin
      last_col_idx = COL_W'(line_width - LW_W'(1));
    end
    last_row_idx = (image_height == '0) ? '0 : image_height - ROW_W'(1);
  end

  assign last_col    = column_count >= last_col_idx;
  assign last_row    = row_count >= last_row_idx;
  assign s1_adv      = s1_valid && (!result_valid || !result_stall);
  assign pixel_stall = s1_valid && !s1_adv;
  assign accept      = pixel_valid && !pixel_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width   <= LW_W'(640);
      image_height <= ROW_W'(480);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LINE_WIDTH:   line_width   <= cfg_data[LW_W-1:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (last_col) begin
          column_count <= '0;
          row_count    <= last_row ? '0 : row_count + ROW_W'(1);
        end else begin
          column_count <= column_count + COL_W'(1);
        end
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix             <= pixel;
      s1_ctrl.col        <= column_count;
      s1_ctrl.col_zero   <= column_count == '0;
      s1_ctrl.last_col   <= last_col;
      s1_ctrl.last_row   <= last_row;
      s1_ctrl.first_row  <= row_count == '0;
    end
    if (s1_adv) begin
      result <= core_result;
    end
  end

  fsd_err_mem u_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (column_count),
    .rd_data (above),
    .wr      (mem_wr)
  );

  fsd_core u_core (
    .clk    (clk),
    .rst    (rst),
    .adv    (s1_adv),
    .ctrl   (s1_ctrl),
    .pix    (s1_pix),
    .above  (above),
    .result (core_result),
    .mem_wr (mem_wr)
  );

  a_row_wrap: assert property (@(posedge clk) disable iff (rst)
    (accept && last_col) |=> (column_count == '0))
    else $error("Column counter did not wrap at the end of a row.");

  a_image_end: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.end_of_image) |-> result.end_of_row)
    else $error("End of image flagged away from a row end.");

  a_stage_to_out: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> result_valid)
    else $error("Quantizer stage advanced without loading the output register.");

endmodule
